@@ src/chte_pkg.sv @@
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types, codes and default sizes for the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int DEF_MAX_BUCKETS = 16;
    localparam int DEF_BUCKET_WAYS = 4;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    // bucket count register
    localparam int              CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // key bits consumed per cycle by the modulo unit
    localparam int DIGIT_W = 4;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [31:0]      key;
        logic [31:0]      value_in;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         value_out;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mem_read;
        logic exec;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

@@ src/chained_hash_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top
// Key-value hash table with bounded buckets: insert/update, lookup, remove.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  cfg       in         i_cfg_we                i_cfg_wdata (bucket count)
//  request   in         i_in_valid / o_in_stall i_in_item (cmd, key, value_in)
//  result    out        o_out_valid/i_out_stall o_out_item (status, value_out)
//
//  one item at a time: the key modulo unit takes four key bits per cycle,
//  then the bucket row is read and then updated
//  the next item is taken while the previous result waits in the output register
//  synchronous reset clears all valid bits at once, no clearing pass
// ----------------------------------------------------------------------------
module chained_hash_table_engine_top import chte_pkg::*; #(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int BUCKET_WAYS = DEF_BUCKET_WAYS,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    chte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    chte_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

@@ src/chte_ctrl.sv @@
// ----------------------------------------------------------------------------
// chte_ctrl
// Request sequencer: accept, modulo steps, bucket read, update, hand-off.
// ----------------------------------------------------------------------------
module chte_ctrl import chte_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_EXEC = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to be free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ src/chte_dp.sv @@
// ----------------------------------------------------------------------------
// chte_dp
// Datapath: bucket count register, digit-serial modulo, bucket row memories,
// way match and update, result and output registers.
// ----------------------------------------------------------------------------
module chte_dp import chte_pkg::*; #(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int BUCKET_WAYS = DEF_BUCKET_WAYS,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat
);

    localparam int STEPS  = (KEY_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W  = STEPS * DIGIT_W;
    localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int WAY_W  = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int REM_W  = CFG_W;
    localparam int KROW_W = BUCKET_WAYS * KEY_BITS;
    localparam int VROW_W = BUCKET_WAYS * VALUE_BITS;

    logic [CFG_W-1:0]       r_cfg;
    logic [CMD_W-1:0]       r_op;
    logic [KEY_BITS-1:0]    r_key;
    logic [VALUE_BITS-1:0]  r_val;
    logic [PAD_W-1:0]       r_shift;
    logic [REM_W-1:0]       r_rem;
    logic [REM_W-1:0]       r_div;
    logic [CNT_W-1:0]       r_cnt;
    logic [BKT_W-1:0]       r_bucket;

    logic [KROW_W-1:0]      r_key_mem [MAX_BUCKETS];
    logic [VROW_W-1:0]      r_val_mem [MAX_BUCKETS];
    logic [BUCKET_WAYS-1:0] r_valid   [MAX_BUCKETS];

    logic [KROW_W-1:0]      r_key_row;
    logic [VROW_W-1:0]      r_val_row;
    logic [BUCKET_WAYS-1:0] r_vrow;

    t_out_item              r_res;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic [REM_W-1:0]       eff_div;
    logic [REM_W:0]         part;
    logic [REM_W-1:0]       rem_next;
    logic                   div_done;

    logic [BUCKET_WAYS-1:0] hit;
    logic [WAY_W-1:0]       m_way;
    logic [WAY_W-1:0]       f_way;
    logic                   any_hit;
    logic                   any_free;
    logic [KROW_W-1:0]      n_key_row;
    logic [VROW_W-1:0]      n_val_row;
    logic [BUCKET_WAYS-1:0] n_vrow;
    logic                   key_we;
    logic                   val_we;
    t_out_item              n_res;

    // zero means one bucket, large counts saturate
    always_comb begin
        eff_div = r_cfg;
        if (r_cfg == '0) begin
            eff_div = REM_W'(1);
        end else if (int'(r_cfg) > MAX_BUCKETS) begin
            eff_div = REM_W'(MAX_BUCKETS);
        end
    end

    // one key digit per cycle, restoring compare and subtract per bit
    always_comb begin
        part     = '0;
        rem_next = r_rem;
        for (int b = 0; b < DIGIT_W; b++) begin
            part = {rem_next, r_shift[PAD_W-1-b]};
            if (part >= {1'b0, r_div}) begin
                part = part - {1'b0, r_div};
            end
            rem_next = part[REM_W-1:0];
        end
    end

    assign div_done = (r_cnt == CNT_W'(STEPS - 1));

    // way match and free way, lowest way wins
    always_comb begin
        m_way    = '0;
        f_way    = '0;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            hit[w] = r_vrow[w] && (r_key_row[w*KEY_BITS +: KEY_BITS] == r_key);
        end
        for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
            if (hit[w]) begin
                m_way = WAY_W'(w);
            end
            if (!r_vrow[w]) begin
                f_way = WAY_W'(w);
            end
        end
        any_hit  = |hit;
        any_free = ~&r_vrow;
    end

    always_comb begin
        n_key_row       = r_key_row;
        n_val_row       = r_val_row;
        n_vrow          = r_vrow;
        key_we          = 1'b0;
        val_we          = 1'b0;
        n_res.status    = ST_NOT_FOUND;
        n_res.value_out = '0;
        case (r_op)
            CMD_INSERT: begin
                if (any_hit) begin
                    n_val_row[m_way*VALUE_BITS +: VALUE_BITS] = r_val;
                    val_we       = 1'b1;
                    n_res.status = ST_UPDATED;
                end else if (any_free) begin
                    n_key_row[f_way*KEY_BITS +: KEY_BITS]     = r_key;
                    n_val_row[f_way*VALUE_BITS +: VALUE_BITS] = r_val;
                    n_vrow[f_way] = 1'b1;
                    key_we        = 1'b1;
                    val_we        = 1'b1;
                    n_res.status  = ST_INSERTED;
                end else begin
                    n_res.status = ST_FULL;
                end
            end
            CMD_LOOKUP: begin
                if (any_hit) begin
                    n_res.status    = ST_FOUND;
                    n_res.value_out = 32'(r_val_row[m_way*VALUE_BITS +: VALUE_BITS]);
                end
            end
            CMD_REMOVE: begin
                if (any_hit) begin
                    n_vrow[m_way] = 1'b0;
                    n_res.status  = ST_FOUND;
                end
            end
            default: begin
                n_res.status = ST_NOT_FOUND;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
            for (int b = 0; b < MAX_BUCKETS; b++) begin
                r_valid[b] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec) begin
                r_valid[r_bucket] <= n_vrow;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_item.cmd;
            r_key   <= KEY_BITS'(i_in_item.key);
            r_val   <= VALUE_BITS'(i_in_item.value_in);
            r_shift <= PAD_W'(KEY_BITS'(i_in_item.key));
            r_rem   <= '0;
            r_cnt   <= '0;
            r_div   <= eff_div;
        end
        if (i_cmd.div_step) begin
            r_shift <= r_shift << DIGIT_W;
            r_rem   <= rem_next;
            r_cnt   <= r_cnt + 1'b1;
            if (div_done) begin
                r_bucket <= BKT_W'(rem_next);
            end
        end
        if (i_cmd.mem_read) begin
            r_vrow <= r_valid[r_bucket];
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out_item <= r_res;
        end
    end

    // bucket row memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_key_row <= r_key_mem[r_bucket];
            r_val_row <= r_val_mem[r_bucket];
        end
        if (i_cmd.exec && key_we) begin
            r_key_mem[r_bucket] <= n_key_row;
        end
        if (i_cmd.exec && val_we) begin
            r_val_mem[r_bucket] <= n_val_row;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

@@ src/chte_checker.sv @@
// ----------------------------------------------------------------------------
// chte_checker
// Port-level checks for the chained hash table engine, bound to the top.
// ----------------------------------------------------------------------------
module chte_checker import chte_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic [CFG_W-1:0] i_cfg_wdata,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input t_in_item         i_in_item,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out_item        o_out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item dropped or changed while stalled");

    // one item in flight: the request side stalls right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while another is in progress");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= ST_FULL)
        else $error("status code out of range");

    // only a successful lookup carries a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_FOUND |-> o_out_item.value_out == '0)
        else $error("value returned without a hit");

    // a request cannot produce a result in the cycle after its accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind chained_hash_table_engine_top chte_checker u_chte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
